// ===== rtl/sbapd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sbapd_pkg;

  // default store depth in values
  localparam int unsigned MaxDimsDefault = 64;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned HalfW   = 7;
  localparam int unsigned ValueW  = 14;
  localparam int unsigned IndexW  = 6;
  localparam int unsigned StatusW = 2;
  localparam int unsigned ExpW    = 7;
  localparam int unsigned BcW     = 15;

  localparam logic [ExpW-1:0] ExpectedReset = 7'd1;

  // result status codes
  localparam logic [StatusW-1:0] StOk       = 2'd0;
  localparam logic [StatusW-1:0] StBadSum   = 2'd1;
  localparam logic [StatusW-1:0] StBadCount = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic                 sum_clear;
    logic                 sum_add;
    logic                 low_load;
    logic                 count_load;
    logic                 bc_clear;
    logic                 bc_inc;
    logic                 ram_wr;
    logic                 status_load;
    logic [StatusW-1:0]   status_code;
    logic                 rd_clear;
    logic                 rd_issue;
    logic                 value_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic byte_zero;
    logic cnt_zero;
    logic cnt_over;
    logic val_done;
    logic skip_done;
    logic sum_ok;
    logic count_ok;
    logic count_zero;
    logic drain_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/sbapd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbapd_ram #(
  parameter int unsigned Width = 14,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [Width-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sbapd_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbapd_dp #(
  parameter int unsigned MAX_DIMS = sbapd_pkg::MaxDimsDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  input  wire logic [sbapd_pkg::ExpW-1:0]   cfg_expected_count_i,
  input  wire logic [sbapd_pkg::ByteW-1:0]  rx_byte_i,
  input  wire logic                         out_ready_i,
  input  wire sbapd_pkg::cmd_t              cmd_i,
  output sbapd_pkg::sts_t                   sts_o,
  output logic                              out_valid_o,
  output logic [sbapd_pkg::ValueW-1:0]      value_o,
  output logic [sbapd_pkg::IndexW-1:0]      index_o,
  output logic                              last_o,
  output logic [sbapd_pkg::StatusW-1:0]     status_o
);

  localparam int unsigned AddrW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned RdW   = $clog2(MAX_DIMS + 1);
  localparam logic [sbapd_pkg::ValueW-1:0] MaxW = sbapd_pkg::ValueW'(MAX_DIMS);

  logic [sbapd_pkg::ExpW-1:0]    expected_q;
  logic [sbapd_pkg::ValueW-1:0]  count_q, count_d;
  logic [sbapd_pkg::BcW-1:0]     bc_q, bc_inc;
  logic [sbapd_pkg::ByteW-1:0]   sum_q;
  logic [sbapd_pkg::HalfW-1:0]   low_q;
  logic [RdW-1:0]                rd_idx_q;
  logic [sbapd_pkg::ValueW-1:0]  rd_ext, drain_n;
  logic [sbapd_pkg::ValueW-1:0]  ram_rdata;
  logic [sbapd_pkg::ValueW-1:0]  new_value;
  logic                          out_valid_q;
  logic                          out_free;

  assign new_value = {rx_byte_i[sbapd_pkg::HalfW-1:0], low_q};
  assign count_d   = new_value;
  assign bc_inc    = bc_q + 1'b1;
  assign rd_ext    = sbapd_pkg::ValueW'(rd_idx_q);
  assign drain_n   = (count_q > MaxW) ? MaxW : count_q;
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    sts_o            = '0;
    sts_o.byte_zero  = (rx_byte_i == '0);
    sts_o.cnt_zero   = (count_d == '0);
    sts_o.cnt_over   = (count_d > MaxW);
    sts_o.val_done   = (bc_inc[sbapd_pkg::BcW-1:1] >= count_q);
    sts_o.skip_done  = (bc_inc >= {count_q, 1'b0});
    sts_o.sum_ok     = ((sum_q | 8'h80) == rx_byte_i);
    sts_o.count_ok   = (count_q == sbapd_pkg::ValueW'(expected_q));
    sts_o.count_zero = (count_q == '0);
    sts_o.drain_last = ((rd_ext + 1'b1) == drain_n);
    sts_o.out_free   = out_free;
  end

  // packet parse registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q <= sbapd_pkg::ExpectedReset;
      count_q    <= '0;
      bc_q       <= '0;
      sum_q      <= '0;
      low_q      <= '0;
      rd_idx_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        expected_q <= cfg_expected_count_i;
      end
      if (cmd_i.sum_clear) begin
        sum_q <= '0;
      end else if (cmd_i.sum_add) begin
        sum_q <= sum_q + rx_byte_i;
      end
      if (cmd_i.low_load) begin
        low_q <= rx_byte_i[sbapd_pkg::HalfW-1:0];
      end
      if (cmd_i.count_load) begin
        count_q <= count_d;
      end
      if (cmd_i.bc_clear) begin
        bc_q <= '0;
      end else if (cmd_i.bc_inc) begin
        bc_q <= bc_inc;
      end
      if (cmd_i.rd_clear) begin
        rd_idx_q <= '0;
      end else if (cmd_i.value_load) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
    end
  end

  sbapd_ram #(
    .Width (sbapd_pkg::ValueW),
    .Depth (MAX_DIMS)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.ram_wr),
    .wr_addr_i (bc_q[AddrW:1]),
    .wr_data_i (new_value),
    .rd_en_i   (cmd_i.rd_issue),
    .rd_addr_i (rd_idx_q[AddrW-1:0]),
    .rd_data_o (ram_rdata)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.status_load || cmd_i.value_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.status_load) begin
      value_o  <= '0;
      index_o  <= '0;
      last_o   <= 1'b1;
      status_o <= cmd_i.status_code;
    end else if (cmd_i.value_load) begin
      value_o  <= ram_rdata;
      index_o  <= rd_ext[sbapd_pkg::IndexW-1:0];
      last_o   <= ((rd_ext + 1'b1) == count_q);
      status_o <= sbapd_pkg::StOk;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.status_load || cmd_i.value_load) |-> out_free)
    else $error("output register loaded while holding an untaken item");

  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.status_load |=> (out_valid_q && last_o && status_o != sbapd_pkg::StOk))
    else $error("status result not presented as final item");

  a_no_wr_during_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.ram_wr && (cmd_i.rd_issue || cmd_i.value_load)))
    else $error("store written during drain");
`endif

endmodule

`default_nettype wire

// ===== rtl/sbapd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbapd_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire sbapd_pkg::sts_t sts_i,
  output sbapd_pkg::cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    PhSync,
    PhCntLo,
    PhCntHi,
    PhValLo,
    PhValHi,
    PhSkip,
    PhCheck,
    PhDrainRd,
    PhDrainWr
  } phase_e;

  phase_e state_q, state_d;
  logic   acc;

  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      PhSync: begin
        in_ready_o = 1'b1;
        if (acc && sts_i.byte_zero) begin
          cmd_o.sum_clear = 1'b1;
          state_d         = PhCntLo;
        end
      end
      PhCntLo: begin
        in_ready_o = 1'b1;
        if (acc) begin
          cmd_o.sum_add  = 1'b1;
          cmd_o.low_load = 1'b1;
          state_d        = PhCntHi;
        end
      end
      PhCntHi: begin
        in_ready_o = 1'b1;
        if (acc) begin
          cmd_o.sum_add    = 1'b1;
          cmd_o.count_load = 1'b1;
          cmd_o.bc_clear   = 1'b1;
          if (sts_i.cnt_zero) begin
            state_d = PhCheck;
          end else if (sts_i.cnt_over) begin
            state_d = PhSkip;
          end else begin
            state_d = PhValLo;
          end
        end
      end
      PhValLo: begin
        in_ready_o = 1'b1;
        if (acc) begin
          cmd_o.sum_add  = 1'b1;
          cmd_o.low_load = 1'b1;
          cmd_o.bc_inc   = 1'b1;
          state_d        = PhValHi;
        end
      end
      PhValHi: begin
        in_ready_o = 1'b1;
        if (acc) begin
          cmd_o.sum_add = 1'b1;
          cmd_o.ram_wr  = 1'b1;
          cmd_o.bc_inc  = 1'b1;
          state_d       = sts_i.val_done ? PhCheck : PhValLo;
        end
      end
      PhSkip: begin
        in_ready_o = 1'b1;
        if (acc) begin
          cmd_o.sum_add = 1'b1;
          cmd_o.bc_inc  = 1'b1;
          if (sts_i.skip_done) begin
            state_d = PhCheck;
          end
        end
      end
      PhCheck: begin
        // the check byte may produce a status item at once
        in_ready_o = sts_i.out_free;
        if (acc) begin
          state_d = PhSync;
          if (!sts_i.sum_ok) begin
            cmd_o.status_load = 1'b1;
            cmd_o.status_code = sbapd_pkg::StBadSum;
          end else if (!sts_i.count_ok) begin
            cmd_o.status_load = 1'b1;
            cmd_o.status_code = sbapd_pkg::StBadCount;
          end else if (!sts_i.count_zero) begin
            cmd_o.rd_clear = 1'b1;
            state_d        = PhDrainRd;
          end
        end
      end
      PhDrainRd: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = PhDrainWr;
      end
      PhDrainWr: begin
        if (sts_i.out_free) begin
          cmd_o.value_load = 1'b1;
          state_d          = sts_i.drain_last ? PhSync : PhDrainRd;
        end
      end
      default: begin
        state_d = PhSync;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PhSync;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef ASSERT_OFF
  a_drain_read_then_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == PhDrainRd) |=> (state_q == PhDrainWr))
    else $error("drain read not followed by output load step");

  a_no_input_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.rd_issue || cmd_o.value_load) |-> !acc)
    else $error("byte accepted during drain");
`endif

endmodule

`default_nettype wire

// ===== rtl/seven_bit_array_packet_deframer_top.sv =====
// seven-bit array packet deframer
// input channel: one rx byte per item (in_valid_i / in_ready_o); bytes are
//   dropped until a zero sync byte, then a 14-bit count (two 7-bit bytes, low
//   first), count values of two 7-bit bytes each, and a check byte
// output channel: value, index, last, status per item (out_valid_o / out_ready_i)
// config channel: expected_count written on cfg_valid_i, always ready
// throughput: one byte per cycle while parsing; results come only on the
//   check byte, which is taken once the output register is free
// a good packet of n values is read back from the value store item by item
//   (store read, then output load), so input is held off after the check byte
//   until the last item is loaded; the store's registered read port sets this
// a bad checksum or wrong count yields one status item in the cycle after the
//   check byte is accepted
// reset: parser waits for sync, expected_count returns to 1, output empty;
//   the store is not cleared
// receiver stall: the held result blocks the next check byte or drain step,
//   ordinary packet bytes keep flowing
`timescale 1ns / 1ps
`default_nettype none

module seven_bit_array_packet_deframer_top #(
  parameter int unsigned MAX_DIMS = sbapd_pkg::MaxDimsDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // config write
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [sbapd_pkg::ExpW-1:0]   cfg_expected_count_i,
  // byte input
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [sbapd_pkg::ByteW-1:0]  rx_byte_i,
  // result output
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [sbapd_pkg::ValueW-1:0]      value_o,
  output logic [sbapd_pkg::IndexW-1:0]      index_o,
  output logic                              last_o,
  output logic [sbapd_pkg::StatusW-1:0]     status_o
);

  sbapd_pkg::cmd_t cmd;
  sbapd_pkg::sts_t sts;

  // config register is a plain write, never back-pressured
  assign cfg_ready_o = 1'b1;

  sbapd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sbapd_dp #(
    .MAX_DIMS (MAX_DIMS)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_expected_count_i (cfg_expected_count_i),
    .rx_byte_i            (rx_byte_i),
    .out_ready_i          (out_ready_i),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .out_valid_o          (out_valid_o),
    .value_o              (value_o),
    .index_o              (index_o),
    .last_o               (last_o),
    .status_o             (status_o)
  );

endmodule

`default_nettype wire
